>>> rtl/wcea_pkg.sv
// Shared constants, codes and types of the weighted counter energy accounting block.
package wcea_pkg;

  localparam int NUM_CPUS     = 4;
  localparam int NUM_COUNTERS = 18;
  localparam int NUM_SLOTS    = 19;
  localparam int WRAP_BITS    = 40;

  localparam int CPU_W    = 2;
  localparam int CNT_W    = 5;
  localparam int SLOT_W   = 5;
  localparam int VALUE_W  = 64;
  localparam int WEIGHT_W = 32;
  localparam int MASK_W   = NUM_COUNTERS;
  localparam int HALF_W   = VALUE_W / 2;

  localparam int ADDR_W    = CPU_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int IN_CPU_LO   = 0;
  localparam int IN_CNT_LO   = IN_CPU_LO + CPU_W;
  localparam int IN_VAL_LO   = IN_CNT_LO + CNT_W;
  localparam int IN_WSLOT_LO = IN_VAL_LO + VALUE_W;
  localparam int IN_WVAL_LO  = IN_WSLOT_LO + SLOT_W;
  localparam int IN_USED_W   = IN_WVAL_LO + WEIGHT_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_USED_W = CPU_W + SLOT_W + 3 * VALUE_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_WEIGHT = 1'b1
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t              kind;
    logic [CPU_W-1:0]         cpu;
    logic [SLOT_W-1:0]        slot;
    logic [VALUE_W-1:0]       value;
  } queue_entry_t;

endpackage

>>> rtl/weighted_counter_energy_accounting.sv
// Top level of the weighted counter energy accounting block.
//
// Input stream (s_axis): one item per handshake. tuser selects the kind of item:
// a counter sample (0) or a slot weight write (1). Samples of disabled counters
// or of counters above NUM_COUNTERS, and weight writes, give no result.
// Output stream (m_axis): one result per kept sample, in input order, with the
// delta since the previous sample of that processor and slot and both energies.
// Configuration: cfg_wr_en writes the counter enable mask from cfg_wr_data.
// Throughput is one item per cycle while the receiver does not stall; the read of
// the stored last value and its rewrite are one stage apart and a forwarding
// register covers back-to-back samples of the same processor and slot.
// At reset the enable mask, all weights and all stored last values read as zero;
// per-entry valid bits clear the last-value memory at once.
// When the receiver stalls, the back pipeline holds and the queue of
// QUEUE_DEPTH items keeps accepting until it is full.
module weighted_counter_energy_accounting #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [wcea_pkg::MASK_W-1:0]     cfg_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: cpu, counter, value, weight_slot, weight_value, zero fill.
  input  logic [wcea_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Field: cmd.
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: out_cpu, slot, delta, diff_energy, raw_energy, zero fill.
  output logic [wcea_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import wcea_pkg::*;

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  queue_entry_t q_in;
  queue_entry_t q_out;

  wcea_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  wcea_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .entry_out (q_out)
  );

  wcea_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_entry       (q_out),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/wcea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wcea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/wcea_front.sv
// Input side: holds the enable mask, classifies items and computes the compact slot.
module wcea_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wcea_pkg::MASK_W-1:0]    cfg_wr_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wcea_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output wcea_pkg::queue_entry_t         q_entry
);
  import wcea_pkg::*;

  localparam int GRP_W  = 6;
  localparam int GROUPS = (NUM_COUNTERS + GRP_W - 1) / GRP_W;
  localparam int GCNT_W = $clog2(GRP_W + 1);

  logic [MASK_W-1:0]   enable_mask;
  logic [CPU_W-1:0]    cpu;
  logic [CNT_W-1:0]    counter;
  logic [VALUE_W-1:0]  value;
  logic [SLOT_W-1:0]   wslot;
  logic [WEIGHT_W-1:0] wvalue;
  logic [MASK_W-1:0]   below;
  logic [SLOT_W-1:0]   slot;
  logic                enabled;
  logic                keep;

  assign cpu    = s_axis_tdata[IN_CNT_LO-1:IN_CPU_LO];
  assign counter = s_axis_tdata[IN_VAL_LO-1:IN_CNT_LO];
  assign value  = s_axis_tdata[IN_WSLOT_LO-1:IN_VAL_LO];
  assign wslot  = s_axis_tdata[IN_WVAL_LO-1:IN_WSLOT_LO];
  assign wvalue = s_axis_tdata[IN_USED_W-1:IN_WVAL_LO];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (cfg_wr_en) begin
      enable_mask <= cfg_wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      below[i] = enable_mask[i] && (CNT_W'(i) < counter);
    end
  end

  always_comb begin
    logic [GCNT_W-1:0] gcnt;
    slot = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gcnt = '0;
      for (int j = 0; j < GRP_W; j++) begin
        if (g * GRP_W + j < NUM_COUNTERS) begin
          gcnt = gcnt + GCNT_W'(below[g * GRP_W + j]);
        end
      end
      slot = slot + SLOT_W'(gcnt);
    end
  end

  always_comb begin
    if (counter < CNT_W'(NUM_COUNTERS)) begin
      enabled = enable_mask[counter];
    end else begin
      enabled = (counter == CNT_W'(NUM_COUNTERS));
    end
  end

  always_comb begin
    q_entry = '0;
    if (s_axis_tuser == CMD_WEIGHT) begin
      keep          = (int'(wslot) < NUM_SLOTS);
      q_entry.kind  = KIND_WEIGHT;
      q_entry.slot  = wslot;
      q_entry.value = VALUE_W'(wvalue);
    end else begin
      keep          = (int'(cpu) < NUM_CPUS) && enabled && (int'(slot) < NUM_SLOTS);
      q_entry.kind  = KIND_SAMPLE;
      q_entry.cpu   = cpu;
      q_entry.slot  = slot;
      q_entry.value = value;
    end
  end

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

>>> rtl/wcea_queue.sv
// Small register queue between the classifying front and the computing back.
module wcea_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wcea_pkg::queue_entry_t entry_in,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output wcea_pkg::queue_entry_t entry_out
);
  import wcea_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign entry_out = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wcea_back.sv
// Compute side: weight writes, last-value lookup with forwarding, delta and energies.
module wcea_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  wcea_pkg::queue_entry_t          q_entry,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wcea_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import wcea_pkg::*;

  localparam int HIGH_W = VALUE_W - WRAP_BITS;

  logic adv;

  logic                s1_valid;
  queue_entry_t        s1_ent;
  logic [ADDR_W-1:0]   s1_addr;

  logic [WEIGHT_W-1:0] weights [NUM_SLOTS];
  logic [MEM_DEPTH-1:0] vld;

  logic                s2_valid;
  logic [CPU_W-1:0]    s2_cpu;
  logic [SLOT_W-1:0]   s2_slot;
  logic [VALUE_W-1:0]  s2_value;
  logic [WEIGHT_W-1:0] s2_weight;
  logic                s2_vld;
  logic [ADDR_W-1:0]   s2_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  last;
  logic [VALUE_W-1:0]  diff;
  logic [VALUE_W-1:0]  delta;

  logic                fwd_valid;
  logic [ADDR_W-1:0]   fwd_addr;
  logic [VALUE_W-1:0]  fwd_data;

  logic                s3_valid;
  logic [CPU_W-1:0]    s3_cpu;
  logic [SLOT_W-1:0]   s3_slot;
  logic [VALUE_W-1:0]  s3_delta;
  logic [VALUE_W-1:0]  s3_value;
  logic [WEIGHT_W-1:0] s3_weight;
  logic [VALUE_W-1:0]  pd_lo;
  logic [VALUE_W-1:0]  pd_hi;
  logic [VALUE_W-1:0]  pr_lo;
  logic [VALUE_W-1:0]  pr_hi;

  logic                s4_valid;
  logic [CPU_W-1:0]    s4_cpu;
  logic [SLOT_W-1:0]   s4_slot;
  logic [VALUE_W-1:0]  s4_delta;
  logic [VALUE_W-1:0]  s4_pd_lo;
  logic [HALF_W-1:0]   s4_pd_hi;
  logic [VALUE_W-1:0]  s4_pr_lo;
  logic [HALF_W-1:0]   s4_pr_hi;

  logic                out_valid;
  logic [CPU_W-1:0]    out_cpu;
  logic [SLOT_W-1:0]   out_slot;
  logic [VALUE_W-1:0]  out_delta;
  logic [VALUE_W-1:0]  out_diff;
  logic [VALUE_W-1:0]  out_raw;

  logic                mem_wr;

  // The whole back pipeline moves together whenever the output register can take an item.
  assign adv     = !out_valid || m_axis_tready;
  assign q_pop   = adv && !q_empty;
  assign s1_addr = {s1_ent.cpu, s1_ent.slot};
  assign mem_wr  = adv && s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ent <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        weights[i] <= '0;
      end
    end else if (adv && s1_valid && s1_ent.kind == KIND_WEIGHT) begin
      weights[s1_ent.slot] <= s1_ent.value[WEIGHT_W-1:0];
    end
  end

  wcea_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MEM_DEPTH)
  ) u_last_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (s2_addr),
    .wr_data (s2_value),
    .rd_en   (adv),
    .rd_addr (s1_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      vld       <= '0;
      fwd_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_ent.kind == KIND_SAMPLE;
      if (s2_valid) begin
        vld[s2_addr] <= 1'b1;
        fwd_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cpu    <= s1_ent.cpu;
      s2_slot   <= s1_ent.slot;
      s2_value  <= s1_ent.value;
      s2_addr   <= s1_addr;
      s2_weight <= weights[s1_ent.slot];
      s2_vld    <= vld[s1_addr];
      if (s2_valid) begin
        fwd_addr <= s2_addr;
        fwd_data <= s2_value;
      end
    end
  end

  always_comb begin
    if (fwd_valid && fwd_addr == s2_addr) begin
      last = fwd_data;
    end else if (s2_vld) begin
      last = rd_data;
    end else begin
      last = '0;
    end
    diff = s2_value - last;
    if (diff[VALUE_W-1:WRAP_BITS] != '0) begin
      delta = {diff[VALUE_W-1:WRAP_BITS] + HIGH_W'(1), diff[WRAP_BITS-1:0]};
    end else begin
      delta = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_comb begin
    pd_lo = s3_delta[HALF_W-1:0] * s3_weight;
    pd_hi = s3_delta[VALUE_W-1:HALF_W] * s3_weight;
    pr_lo = s3_value[HALF_W-1:0] * s3_weight;
    pr_hi = s3_value[VALUE_W-1:HALF_W] * s3_weight;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cpu    <= s2_cpu;
      s3_slot   <= s2_slot;
      s3_delta  <= delta;
      s3_value  <= s2_value;
      s3_weight <= s2_weight;

      s4_cpu   <= s3_cpu;
      s4_slot  <= s3_slot;
      s4_delta <= s3_delta;
      s4_pd_lo <= pd_lo;
      s4_pd_hi <= pd_hi[HALF_W-1:0];
      s4_pr_lo <= pr_lo;
      s4_pr_hi <= pr_hi[HALF_W-1:0];

      out_cpu   <= s4_cpu;
      out_slot  <= s4_slot;
      out_delta <= s4_delta;
      out_diff  <= s4_pd_lo + {s4_pd_hi, HALF_W'(0)};
      out_raw   <= s4_pr_lo + {s4_pr_hi, HALF_W'(0)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_raw, out_diff, out_delta, out_slot, out_cpu});

endmodule
